// ===== design/tbkt_pkg.sv =====
// ----------------------------------------------------------------------------
// tbkt_pkg
// Shared types, codes and constants of the three-level token bucket limiter.
// ----------------------------------------------------------------------------
package tbkt_pkg;

  localparam int TOKEN_BITS   = 16;
  localparam int STAMP_BITS   = 32;
  localparam int CLIENT_SLOTS = 256;
  localparam int KEY_SLOTS    = 256;
  localparam int CLI_IDX_BITS = $clog2(CLIENT_SLOTS);
  localparam int KEY_IDX_BITS = $clog2(KEY_SLOTS);
  localparam int ENTRY_BITS   = TOKEN_BITS + STAMP_BITS;

  // Refill window in seconds and the width of a count of seconds inside it.
  localparam int WINDOW   = 60;
  localparam int WIN_BITS = 6;

  // A capacity splits into WINDOW * quo + rem.
  localparam int QUO_BITS = TOKEN_BITS - 5;

  // x / 60 for a 16-bit x: (x >> 2) * CAP_RECIP >> CAP_SHIFT is exact.
  localparam int CAP_RECIP = 17477;
  localparam int CAP_SHIFT = 18;

  // y / 15 for y below 1489: y * DIV15_MUL >> DIV15_SHIFT is exact.
  localparam int DIV15_MUL   = 1093;
  localparam int DIV15_SHIFT = 14;

  localparam logic [TOKEN_BITS-1:0] GLOBAL_LIMIT_RST = 16'd1000;
  localparam logic [TOKEN_BITS-1:0] CLIENT_LIMIT_RST = 16'd100;
  localparam logic [TOKEN_BITS-1:0] KEY_LIMIT_RST    = 16'd100;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_GLOBAL = 2'd1,
    VERDICT_CLIENT = 2'd2,
    VERDICT_KEY    = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    CFG_GLOBAL_LIMIT = 2'd0,
    CFG_CLIENT_LIMIT = 2'd1,
    CFG_KEY_LIMIT    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TOKEN_BITS-1:0] limit;
    logic [QUO_BITS-1:0]   quo;
    logic [WIN_BITS-1:0]   rem;
  } cap_t;

  typedef struct packed {
    logic [STAMP_BITS-1:0] stamp;
    logic [TOKEN_BITS-1:0] tokens;
  } bucket_t;

  typedef struct packed {
    logic [TOKEN_BITS-1:0] tokens;
    logic [STAMP_BITS-1:0] stamp;
    logic [WIN_BITS-1:0]   left_new;
    logic [WIN_BITS-1:0]   left_old;
  } refill_t;

endpackage

// ===== design/tbkt_ram.sv =====
// ----------------------------------------------------------------------------
// tbkt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tbkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tbkt_cfg.sv =====
// ----------------------------------------------------------------------------
// tbkt_cfg
// Limit registers, each with its capacity split into whole tokens per second
// and a remainder, so that a refill needs no divider.
// ----------------------------------------------------------------------------
module tbkt_cfg
  import tbkt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [TOKEN_BITS-1:0] cfg_wdata,
  output cap_t                  glb_cap,
  output cap_t                  cli_cap,
  output cap_t                  key_cap
);

  logic [TOKEN_BITS-1:0] limit_r [3];
  logic [QUO_BITS-1:0]   quo_r [3];
  logic [WIN_BITS-1:0]   rem_r [3];
  logic [QUO_BITS-1:0]   quo_nxt [3];
  logic [WIN_BITS-1:0]   rem_nxt [3];
  logic [TOKEN_BITS+QUO_BITS+1:0] recip_prod [3];
  logic [TOKEN_BITS:0]   rem_wide [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r[0] <= GLOBAL_LIMIT_RST;
      limit_r[1] <= CLIENT_LIMIT_RST;
      limit_r[2] <= KEY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GLOBAL_LIMIT: limit_r[0] <= cfg_wdata;
        CFG_CLIENT_LIMIT: limit_r[1] <= cfg_wdata;
        CFG_KEY_LIMIT:    limit_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Quotient by reciprocal multiply; the split follows the limit in the next
  // cycle, before an item accepted after the write reaches the refill stage.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      recip_prod[i] = (TOKEN_BITS+QUO_BITS+2)'(limit_r[i][TOKEN_BITS-1:2])
                    * (TOKEN_BITS+QUO_BITS+2)'(CAP_RECIP);
      quo_nxt[i]    = recip_prod[i][CAP_SHIFT +: QUO_BITS];
      rem_wide[i]   = (TOKEN_BITS+1)'(limit_r[i])
                    - (TOKEN_BITS+1)'(quo_nxt[i]) * (TOKEN_BITS+1)'(WINDOW);
      rem_nxt[i]    = rem_wide[i][WIN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      quo_r[i] <= quo_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
  end

  assign glb_cap = '{limit: limit_r[0], quo: quo_r[0], rem: rem_r[0]};
  assign cli_cap = '{limit: limit_r[1], quo: quo_r[1], rem: rem_r[1]};
  assign key_cap = '{limit: limit_r[2], quo: quo_r[2], rem: rem_r[2]};

endmodule

// ===== design/tbkt_refill.sv =====
// ----------------------------------------------------------------------------
// tbkt_refill
// Two-stage refill lane for one bucket: elapsed time and partial products,
// then the fractional part, the sum and the clamp to capacity.
// ----------------------------------------------------------------------------
module tbkt_refill
  import tbkt_pkg::*;
(
  input  logic                  clk,
  input  logic                  en_mul,
  input  logic                  en_add,
  input  logic [STAMP_BITS-1:0] now,
  input  bucket_t               entry,
  input  logic                  fresh,
  input  cap_t                  cap,
  output refill_t               result
);

  localparam int AE_BITS   = QUO_BITS + WIN_BITS;
  localparam int BE_BITS   = 2 * WIN_BITS;
  localparam int FP_BITS   = DIV15_SHIFT + 7;
  localparam int SUM_BITS  = TOKEN_BITS + 2;

  logic [TOKEN_BITS-1:0] base_tok;
  logic [STAMP_BITS-1:0] base_stamp;
  logic [STAMP_BITS-1:0] elapsed;
  logic                  full;
  logic [WIN_BITS-1:0]   secs;
  logic [WIN_BITS-1:0]   left;

  logic [TOKEN_BITS-1:0] tok_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic                  full_r;
  logic                  zero_r;
  logic [AE_BITS-1:0]    ae_r;
  logic [BE_BITS-1:0]    be_r;
  logic [WIN_BITS-1:0]   left_new_r;
  logic [WIN_BITS-1:0]   left_old_r;

  logic [FP_BITS-1:0]    frac_prod;
  logic [SUM_BITS-1:0]   sum;
  logic [TOKEN_BITS-1:0] tok_nxt;
  refill_t               res_r;

  // An entry seen for the first time starts full with a stamp of now.
  always_comb begin
    base_tok   = fresh ? cap.limit : entry.tokens;
    base_stamp = fresh ? now : entry.stamp;
    elapsed    = now - base_stamp;
    full       = elapsed >= STAMP_BITS'(WINDOW);
    secs       = elapsed[WIN_BITS-1:0];
    left       = WIN_BITS'(WINDOW) - secs;
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      tok_r      <= base_tok;
      stamp_r    <= full ? now : base_stamp;
      full_r     <= full;
      zero_r     <= (elapsed == '0);
      ae_r       <= AE_BITS'(cap.quo) * AE_BITS'(secs);
      be_r       <= BE_BITS'(cap.rem) * BE_BITS'(secs);
      left_new_r <= full ? WIN_BITS'(WINDOW) : left;
      left_old_r <= full ? '0 : left;
    end
  end

  // capacity * secs / 60 = quo * secs + (rem * secs) / 60.
  always_comb begin
    frac_prod = FP_BITS'(be_r[BE_BITS-1:2]) * FP_BITS'(DIV15_MUL);
    sum       = SUM_BITS'(tok_r) + SUM_BITS'(ae_r)
              + SUM_BITS'(frac_prod[DIV15_SHIFT +: 7]);
    if (full_r) begin
      tok_nxt = cap.limit;
    end else if (zero_r) begin
      tok_nxt = tok_r;
    end else if (sum > SUM_BITS'(cap.limit)) begin
      tok_nxt = cap.limit;
    end else begin
      tok_nxt = sum[TOKEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_add) begin
      res_r <= '{tokens: tok_nxt, stamp: stamp_r, left_new: left_new_r,
                 left_old: left_old_r};
    end
  end

  assign result = res_r;

endmodule

// ===== design/three_level_token_bucket_limiter_core.sv =====
// ----------------------------------------------------------------------------
// three_level_token_bucket_limiter_core
// Per-minute token bucket limiter with a global, a per-client and a per-key
// level. Tick and clear beats take effect in the cycle they are accepted and
// the block can take another beat in the next cycle. A request or a query
// reads the client and key tables at the accepting edge, then passes through
// two refill states (partial products, then sum and clamp) and a write-back
// state that loads the result register. The next beat is accepted in the
// cycle after the write-back, so these items do not overlap. A result
// that is not taken holds the write-back cycle until the output register is
// free. The tables start empty through valid bits, so there is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module three_level_token_bucket_limiter_core
  import tbkt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [TOKEN_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_client_slot,
  input  logic                  in_has_key,
  input  logic [7:0]            in_key_slot,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_allowed,
  output logic [1:0]            out_verdict,
  output logic [TOKEN_BITS-1:0] out_remaining,
  output logic [WIN_BITS-1:0]   out_secs_left
);

  cap_t glb_cap, cli_cap, key_cap;

  state_t state_r, state_nxt;
  logic   acc, advance, en_mul, en_add, wb;

  logic [STAMP_BITS-1:0]   sec_r;
  logic [TOKEN_BITS-1:0]   glb_tok_r;
  logic [STAMP_BITS-1:0]   glb_stamp_r;
  logic [CLIENT_SLOTS-1:0] cli_valid_r;
  logic [KEY_SLOTS-1:0]    key_valid_r;

  action_t                 act_r;
  logic [CLI_IDX_BITS-1:0] ci_r;
  logic [KEY_IDX_BITS-1:0] ki_r;
  logic                    hk_r, cvalid_r, kvalid_r;

  logic [ENTRY_BITS-1:0] cli_rdata, key_rdata;
  bucket_t               cli_wdata, key_wdata, glb_entry;
  logic                  cli_we, key_we;
  refill_t               glb_res, cli_res, key_res;

  logic     is_req, gzero, czero, kzero, admit;
  verdict_t verdict;

  logic                  out_valid_r, out_allowed_r;
  logic [1:0]            out_verdict_r;
  logic [TOKEN_BITS-1:0] out_remaining_r;
  logic [WIN_BITS-1:0]   out_secs_left_r;

  tbkt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .glb_cap   (glb_cap),
    .cli_cap   (cli_cap),
    .key_cap   (key_cap)
  );

  // ---------------- sequencer ----------------
  assign acc     = in_valid && !in_stall;
  assign advance = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && (in_action inside {ACT_REQUEST, ACT_QUERY})) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (advance) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    en_mul   = 1'b0;
    en_add   = 1'b0;
    wb       = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_MUL:  en_mul = 1'b1;
      ST_ADD:  en_add = 1'b1;
      ST_DONE: wb = advance;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- tables ----------------
  tbkt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CLIENT_SLOTS)) u_cli_ram (
    .clk   (clk),
    .we    (cli_we),
    .waddr (ci_r),
    .wdata (cli_wdata),
    .re    (acc),
    .raddr (in_client_slot[CLI_IDX_BITS-1:0]),
    .rdata (cli_rdata)
  );

  tbkt_ram #(.WIDTH(ENTRY_BITS), .DEPTH(KEY_SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (ki_r),
    .wdata (key_wdata),
    .re    (acc),
    .raddr (in_key_slot[KEY_IDX_BITS-1:0]),
    .rdata (key_rdata)
  );

  // ---------------- refill lanes ----------------
  assign glb_entry = '{stamp: glb_stamp_r, tokens: glb_tok_r};

  tbkt_refill u_glb_refill (
    .clk    (clk),
    .en_mul (en_mul),
    .en_add (en_add),
    .now    (sec_r),
    .entry  (glb_entry),
    .fresh  (1'b0),
    .cap    (glb_cap),
    .result (glb_res)
  );

  tbkt_refill u_cli_refill (
    .clk    (clk),
    .en_mul (en_mul),
    .en_add (en_add),
    .now    (sec_r),
    .entry  (bucket_t'(cli_rdata)),
    .fresh  (!cvalid_r),
    .cap    (cli_cap),
    .result (cli_res)
  );

  tbkt_refill u_key_refill (
    .clk    (clk),
    .en_mul (en_mul),
    .en_add (en_add),
    .now    (sec_r),
    .entry  (bucket_t'(key_rdata)),
    .fresh  (!kvalid_r),
    .cap    (key_cap),
    .result (key_res)
  );

  // ---------------- decision and write-back ----------------
  always_comb begin
    is_req = (act_r == ACT_REQUEST);
    gzero  = (glb_res.tokens == '0);
    czero  = (cli_res.tokens == '0);
    kzero  = (key_res.tokens == '0);
    admit  = !gzero && !czero && !(hk_r && kzero);
    if (gzero) begin
      verdict = VERDICT_GLOBAL;
    end else if (czero) begin
      verdict = VERDICT_CLIENT;
    end else if (hk_r && kzero) begin
      verdict = VERDICT_KEY;
    end else begin
      verdict = VERDICT_OK;
    end
    cli_we    = wb && is_req && !gzero;
    key_we    = wb && is_req && !gzero && !czero && hk_r;
    cli_wdata = '{stamp: cli_res.stamp,
                  tokens: cli_res.tokens - TOKEN_BITS'(admit)};
    key_wdata = '{stamp: key_res.stamp,
                  tokens: key_res.tokens - TOKEN_BITS'(admit)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r       <= '0;
      glb_tok_r   <= GLOBAL_LIMIT_RST;
      glb_stamp_r <= '0;
      cli_valid_r <= '0;
      key_valid_r <= '0;
    end else begin
      if (acc && (in_action == ACT_TICK)) begin
        sec_r <= sec_r + 1'b1;
      end
      if (acc && (in_action == ACT_CLEAR)) begin
        cli_valid_r <= '0;
        key_valid_r <= '0;
        glb_tok_r   <= glb_cap.limit;
        glb_stamp_r <= sec_r;
      end
      // The global bucket keeps its refill even when the request is refused.
      if (wb && is_req) begin
        glb_tok_r   <= glb_res.tokens - TOKEN_BITS'(admit);
        glb_stamp_r <= glb_res.stamp;
      end
      if (cli_we) begin
        cli_valid_r[ci_r] <= 1'b1;
      end
      if (key_we) begin
        key_valid_r[ki_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      act_r    <= action_t'(in_action);
      ci_r     <= in_client_slot[CLI_IDX_BITS-1:0];
      ki_r     <= in_key_slot[KEY_IDX_BITS-1:0];
      hk_r     <= in_has_key;
      cvalid_r <= cli_valid_r[in_client_slot[CLI_IDX_BITS-1:0]];
      kvalid_r <= key_valid_r[in_key_slot[KEY_IDX_BITS-1:0]];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb) begin
      if (is_req) begin
        out_allowed_r   <= admit;
        out_verdict_r   <= verdict;
        out_remaining_r <= gzero ? '0 : cli_res.tokens;
        out_secs_left_r <= gzero ? '0 : cli_res.left_new;
      end else begin
        out_allowed_r   <= 1'b0;
        out_verdict_r   <= VERDICT_OK;
        out_remaining_r <= cvalid_r ? cli_res.tokens : cli_cap.limit;
        out_secs_left_r <= cvalid_r ? cli_res.left_old : '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_allowed   = out_allowed_r;
  assign out_verdict   = out_verdict_r;
  assign out_remaining = out_remaining_r;
  assign out_secs_left = out_secs_left_r;

  // ---------------- assertions ----------------
  a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result appeared without a write-back cycle");

  a_table_write_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (cli_we || key_we) |-> (state_r == ST_DONE && is_req))
    else $error("table written outside the write-back of a request");

  a_key_needs_client: assert property (@(posedge clk) disable iff (!rst_n)
    key_we |-> cli_we)
    else $error("key bucket written while the client bucket was not");

  a_allowed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_allowed) |-> (out_verdict == VERDICT_OK))
    else $error("admitted beat carries a refusal verdict");

  a_secs_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_secs_left <= WIN_BITS'(WINDOW)))
    else $error("window time beyond one minute");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the three-level token bucket limiter. A directed
// table covers first sight, every refusal level and the limit extremes, then
// random phases with fresh limits mix ticks, requests, queries and clears.
// Typed rows are checked against the table, the rest against a bucket predictor.
// ----------------------------------------------------------------------------
module testbench;
  import tbkt_pkg::*;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    action_t              action;
    logic [7:0]           client_slot;
    logic                 has_key;
    logic [7:0]           key_slot;
  } limiter_item_t;

  typedef struct packed {
    logic                  allowed;
    verdict_t              verdict;
    logic [TOKEN_BITS-1:0] remaining;
    logic [WIN_BITS-1:0]   secs_left;
  } verdict_beat_t;

  typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_idx_t              reg_idx;
    logic [TOKEN_BITS-1:0] reg_value;
    limiter_item_t         beat;
    logic                  typed;
    verdict_beat_t         want;
  } stim_row_t;

  localparam int DIR_ROWS = 23;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = CFG_GLOBAL_LIMIT;
  logic [TOKEN_BITS-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_action = ACT_TICK;
  logic [7:0]            in_client_slot = '0;
  logic                  in_has_key = 1'b0;
  logic [7:0]            in_key_slot = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_allowed;
  logic [1:0]            out_verdict;
  logic [TOKEN_BITS-1:0] out_remaining;
  logic [WIN_BITS-1:0]   out_secs_left;

  three_level_token_bucket_limiter_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_client_slot(in_client_slot),
    .in_has_key    (in_has_key),
    .in_key_slot   (in_key_slot),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_allowed   (out_allowed),
    .out_verdict   (out_verdict),
    .out_remaining (out_remaining),
    .out_secs_left (out_secs_left)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predicted limiter state.
  logic [TOKEN_BITS-1:0] lim_global = GLOBAL_LIMIT_RST;
  logic [TOKEN_BITS-1:0] lim_client = CLIENT_LIMIT_RST;
  logic [TOKEN_BITS-1:0] lim_key    = KEY_LIMIT_RST;
  logic [31:0] now_sec = '0;
  logic [31:0] glb_tokens = 32'(GLOBAL_LIMIT_RST);
  logic [31:0] glb_stamp = '0;
  logic        cli_seen   [CLIENT_SLOTS];
  logic [31:0] cli_tokens [CLIENT_SLOTS];
  logic [31:0] cli_stamp  [CLIENT_SLOTS];
  logic        key_seen   [KEY_SLOTS];
  logic [31:0] key_tokens [KEY_SLOTS];
  logic [31:0] key_stamp  [KEY_SLOTS];

  verdict_beat_t pending_verdicts[$];
  int unsigned   failures = 0;
  int unsigned   tx_max = 10;
  int unsigned   rx_max = 10;
  int unsigned   hold_cycles = 0;
  int unsigned   quiet_cycles = 0;

  localparam verdict_beat_t NO_BEAT = '{1'b0, VERDICT_OK, 16'd0, 6'd0};

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_QUERY, 8'd0, 1'b0, 8'd0},
      1'b1, '{1'b0, VERDICT_OK, 16'd100, 6'd0}},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_REQUEST, 8'd0, 1'b0, 8'd0},
      1'b1, '{1'b1, VERDICT_OK, 16'd100, 6'd60}},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_REQUEST, 8'd255, 1'b1, 8'd255},
      1'b1, '{1'b1, VERDICT_OK, 16'd100, 6'd60}},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_QUERY, 8'd0, 1'b0, 8'd0},
      1'b1, '{1'b0, VERDICT_OK, 16'd99, 6'd60}},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_TICK, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_QUERY, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_WRITE, CFG_KEY_LIMIT, 16'd0, '{ACT_TICK, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_REQUEST, 8'd1, 1'b1, 8'd0},
      1'b1, '{1'b0, VERDICT_KEY, 16'd100, 6'd60}},
    '{ROW_WRITE, CFG_CLIENT_LIMIT, 16'd0, '{ACT_TICK, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_REQUEST, 8'd2, 1'b1, 8'd1},
      1'b1, '{1'b0, VERDICT_CLIENT, 16'd0, 6'd60}},
    '{ROW_WRITE, CFG_GLOBAL_LIMIT, 16'd0, '{ACT_TICK, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_CLEAR, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_REQUEST, 8'd3, 1'b0, 8'd0},
      1'b1, '{1'b0, VERDICT_GLOBAL, 16'd0, 6'd0}},
    '{ROW_WRITE, CFG_GLOBAL_LIMIT, 16'hFFFF, '{ACT_TICK, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_WRITE, CFG_CLIENT_LIMIT, 16'hFFFF, '{ACT_TICK, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_WRITE, CFG_KEY_LIMIT, 16'hFFFF, '{ACT_TICK, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_CLEAR, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_REQUEST, 8'd4, 1'b1, 8'd2},
      1'b1, '{1'b1, VERDICT_OK, 16'hFFFF, 6'd60}},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_QUERY, 8'd4, 1'b0, 8'd0},
      1'b1, '{1'b0, VERDICT_OK, 16'hFFFE, 6'd60}},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_QUERY, 8'd200, 1'b0, 8'd0},
      1'b1, '{1'b0, VERDICT_OK, 16'hFFFF, 6'd0}},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_TICK, 8'd0, 1'b0, 8'd0},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_REQUEST, 8'd4, 1'b1, 8'd2},
      1'b0, NO_BEAT},
    '{ROW_BEAT,  CFG_GLOBAL_LIMIT, 16'd0, '{ACT_REQUEST, 8'd255, 1'b0, 8'd255},
      1'b0, NO_BEAT}
  };

  // Per-minute refill: a full window restarts the bucket, a partial one adds
  // a share of the capacity but keeps the old stamp.
  function automatic void apply_refill(inout logic [31:0] tok, inout logic [31:0] stamp,
                                       input logic [31:0] cap);
    logic [31:0] elapsed;
    logic [63:0] sum;
    elapsed = now_sec - stamp;
    if (elapsed >= WINDOW) begin
      tok   = cap;
      stamp = now_sec;
    end else if (elapsed != 0) begin
      sum = {32'd0, tok} + ({32'd0, cap} * {32'd0, elapsed}) / WINDOW;
      tok = (sum > {32'd0, cap}) ? cap : sum[31:0];
    end
  endfunction

  function automatic logic [WIN_BITS-1:0] window_left(input logic [31:0] stamp);
    logic [31:0] elapsed;
    elapsed = now_sec - stamp;
    return (elapsed >= WINDOW) ? '0 : WIN_BITS'(WINDOW - elapsed);
  endfunction

  function automatic logic [TOKEN_BITS-1:0] clamp_tokens(input logic [31:0] tok);
    return (tok > 32'hFFFF) ? 16'hFFFF : tok[TOKEN_BITS-1:0];
  endfunction

  // Advances the predicted state by one item; returns 1 when it yields a
  // result beat.
  function automatic bit predict_verdict(input limiter_item_t it, output verdict_beat_t res);
    logic [31:0] t, s, ccap, kcap;
    int unsigned ci, ki;
    ci   = it.client_slot % CLIENT_SLOTS;
    ki   = it.key_slot % KEY_SLOTS;
    ccap = 32'(lim_client);
    kcap = 32'(lim_key);
    res  = '{1'b0, VERDICT_OK, '0, '0};
    case (it.action)
      ACT_TICK: begin
        now_sec = now_sec + 1;
        return 1'b0;
      end
      ACT_CLEAR: begin
        foreach (cli_seen[i]) cli_seen[i] = 1'b0;
        foreach (key_seen[i]) key_seen[i] = 1'b0;
        glb_tokens = 32'(lim_global);
        glb_stamp  = now_sec;
        return 1'b0;
      end
      ACT_QUERY: begin
        if (!cli_seen[ci]) begin
          res.remaining = lim_client;
        end else begin
          t = cli_tokens[ci];
          s = cli_stamp[ci];
          apply_refill(t, s, ccap);
          res.remaining = clamp_tokens(t);
          res.secs_left = window_left(cli_stamp[ci]);
        end
      end
      default: begin
        apply_refill(glb_tokens, glb_stamp, 32'(lim_global));
        if (glb_tokens == 0) begin
          res.verdict = VERDICT_GLOBAL;
        end else begin
          if (!cli_seen[ci]) begin
            cli_seen[ci]   = 1'b1;
            cli_tokens[ci] = ccap;
            cli_stamp[ci]  = now_sec;
          end
          t = cli_tokens[ci];
          s = cli_stamp[ci];
          apply_refill(t, s, ccap);
          cli_tokens[ci] = t;
          cli_stamp[ci]  = s;
          res.remaining  = clamp_tokens(t);
          res.secs_left  = window_left(s);
          if (t == 0) begin
            res.verdict = VERDICT_CLIENT;
          end else if (it.has_key) begin
            if (!key_seen[ki]) begin
              key_seen[ki]   = 1'b1;
              key_tokens[ki] = kcap;
              key_stamp[ki]  = now_sec;
            end
            t = key_tokens[ki];
            s = key_stamp[ki];
            apply_refill(t, s, kcap);
            key_stamp[ki] = s;
            if (t == 0) res.verdict = VERDICT_KEY;
            else t = t - 1;
            key_tokens[ki] = t;
          end
          if (res.verdict == VERDICT_OK) begin
            glb_tokens     = glb_tokens - 1;
            cli_tokens[ci] = cli_tokens[ci] - 1;
            res.allowed    = 1'b1;
          end
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic logic [TOKEN_BITS-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3, 4: return TOKEN_BITS'($urandom_range(1, 6));
      5, 6, 7: return TOKEN_BITS'($urandom_range(7, 300));
      default: return TOKEN_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_slot();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'($urandom_range(0, 7));
    if (r == 7) return 8'd255;
    return 8'($urandom());
  endfunction

  // Holds the sender back until every predicted verdict has come back,
  // then lets the last tick or clear settle.
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_limit(input cfg_idx_t idx, input logic [TOKEN_BITS-1:0] value);
    wait_for_verdicts();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GLOBAL_LIMIT: lim_global = value;
      CFG_CLIENT_LIMIT: lim_client = value;
      default:          lim_key    = value;
    endcase
  endtask

  task automatic send_item(input limiter_item_t it, input int unsigned gap,
                           input logic typed, input verdict_beat_t typed_want);
    verdict_beat_t predicted;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= it.action;
    in_client_slot <= it.client_slot;
    in_has_key     <= it.has_key;
    in_key_slot    <= it.key_slot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_verdict(it, predicted))
      pending_verdicts.push_back(typed ? typed_want : predicted);
  endtask

  task automatic check_verdict();
    verdict_beat_t want;
    if (pending_verdicts.size() == 0) begin
      $error("result beat with nothing expected: allowed %0d verdict %0d",
             out_allowed, out_verdict);
      failures++;
    end else begin
      want = pending_verdicts.pop_front();
      if (out_allowed !== want.allowed) begin
        $error("allowed: expected %0d, actual %0d", want.allowed, out_allowed);
        failures++;
      end
      if (out_verdict !== want.verdict) begin
        $error("verdict: expected %0d, actual %0d", want.verdict, out_verdict);
        failures++;
      end
      if (out_remaining !== want.remaining) begin
        $error("remaining: expected %0d, actual %0d", want.remaining, out_remaining);
        failures++;
      end
      if (out_secs_left !== want.secs_left) begin
        $error("secs_left: expected %0d, actual %0d", want.secs_left, out_secs_left);
        failures++;
      end
    end
  endtask

  // Result side: every taken beat draws a fresh stall stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_verdict();
      hold_cycles = $urandom_range(0, rx_max);
    end else if (hold_cycles != 0) begin
      hold_cycles = hold_cycles - 1;
    end
    out_stall <= (hold_cycles != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    limiter_item_t it;
    int unsigned   sent;
    int unsigned   r;
    int unsigned   burst;
    foreach (cli_seen[i]) begin
      cli_seen[i]   = 1'b0;
      cli_tokens[i] = '0;
      cli_stamp[i]  = '0;
    end
    foreach (key_seen[i]) begin
      key_seen[i]   = 1'b0;
      key_tokens[i] = '0;
      key_stamp[i]  = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        program_limit(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      else
        send_item(directed_rows[i].beat, $urandom_range(0, 10), directed_rows[i].typed,
                  directed_rows[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      program_limit(CFG_GLOBAL_LIMIT, pick_limit());
      program_limit(CFG_CLIENT_LIMIT, pick_limit());
      program_limit(CFG_KEY_LIMIT, pick_limit());
      // Some phases run one side without any idling at all.
      tx_max = (phase % 3 == 1) ? 0 : 10;
      rx_max = (phase % 3 == 2) ? 0 : 10;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        it.client_slot = pick_slot();
        it.key_slot    = pick_slot();
        it.has_key     = 1'($urandom_range(0, 1));
        if (r < 3) begin
          // A run of ticks can push buckets past their window.
          burst = $urandom_range(20, 70);
          it.action = ACT_TICK;
          repeat (burst) send_item(it, $urandom_range(0, tx_max), 1'b0, NO_BEAT);
          sent += burst;
        end else begin
          if (r < 53)      it.action = ACT_REQUEST;
          else if (r < 76) it.action = ACT_TICK;
          else if (r < 97) it.action = ACT_QUERY;
          else             it.action = ACT_CLEAR;
          send_item(it, $urandom_range(0, tx_max), 1'b0, NO_BEAT);
          sent++;
        end
        if ($urandom_range(0, 99) == 0) wait_for_verdicts();
      end
    end

    wait_for_verdicts();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tbkt_pkg.sv
design/tbkt_ram.sv
design/tbkt_cfg.sv
design/tbkt_refill.sv
design/three_level_token_bucket_limiter_core.sv
tb/testbench.sv
